// ----- hw/rtl/hta_pkg.sv -----
// Shared types and codes for the hole table fit allocator.
package hta_pkg;

  // Operation carried in tuser of the input item.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_ADD   = 1'b1;

  // Placement policy register codes.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned HOLES_W     = 5;
  localparam int unsigned IN_TDATA_W  = 3 * FIELD_W;
  localparam int unsigned OUT_TDATA_W = 40;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } hta_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } hta_sts_t;

endpackage

// ----- hw/rtl/hta_ctrl.sv -----
// Sequencing state machine of the hole table fit allocator.
module hta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output hta_pkg::hta_cmd_t cmd_o,
  input  hta_pkg::hta_sts_t sts_i
);
  import hta_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // The last entry read is compared during this cycle.
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/hta_dp.sv -----
// Datapath of the hole table fit allocator: hole memory, scan, selection and result register.
module hta_dp #(
  parameter int unsigned MAX_HOLES  = 16,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hta_pkg::hta_cmd_t                  cmd_i,
  output hta_pkg::hta_sts_t                  sts_o,
  input  logic [hta_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  logic                               in_func_i,
  input  logic                               cfg_valid_i,
  input  logic [1:0]                         cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [hta_pkg::OUT_TDATA_W-1:0]    out_data_o,
  output logic [1:0]                         out_status_o
);
  import hta_pkg::*;

  localparam int unsigned IW = $clog2(MAX_HOLES);
  localparam int unsigned CW = $clog2(MAX_HOLES + 1);
  localparam int unsigned EW = ADDR_WIDTH + FIELD_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_HOLES - 1);

  // Each entry holds {base, size}.
  logic [EW-1:0]          mem [MAX_HOLES];
  logic [MAX_HOLES-1:0]   valid_q;
  logic [CW-1:0]          count_q, count_d;
  logic [1:0]             policy_q;

  logic                   func_q;
  logic [FIELD_W-1:0]     req_q, nsize_q;
  logic [ADDR_WIDTH-1:0]  nbase_q;

  logic [IW-1:0]          idx_q;
  logic                   rd_vld_q;
  logic [IW-1:0]          rd_idx_q;
  logic                   rd_v_q;
  logic [EW-1:0]          rd_q;
  logic [ADDR_WIDTH-1:0]  rd_start;
  logic [FIELD_W-1:0]     rd_len;

  logic                   pick_found_q;
  logic [IW-1:0]          pick_idx_q;
  logic [ADDR_WIDTH-1:0]  pick_start_q;
  logic [FIELD_W-1:0]     pick_len_q;
  logic                   free_found_q;
  logic [IW-1:0]          free_idx_q;

  logic                   fits, better, lower_base;

  logic                   we;
  logic [IW-1:0]          waddr;
  logic [EW-1:0]          wdata;
  logic                   set_v, clr_v;
  logic [FIELD_W-1:0]     res_base;
  logic [1:0]             res_status;
  logic [31:0]            count_ext;

  logic                   out_valid_q;
  logic [FIELD_W-1:0]     out_base_q;
  logic [HOLES_W-1:0]     out_holes_q;
  logic [1:0]             out_status_q;

  assign rd_start = rd_q[EW-1:FIELD_W];
  assign rd_len   = rd_q[FIELD_W-1:0];

  assign sts_o.scan_last = (idx_q == LAST_IDX);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Hole memory: one read port for the scan, one write port for the commit.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[idx_q];
  end

  // Candidate comparison for the entry read in the previous cycle.
  always_comb begin
    fits       = rd_v_q && (rd_len >= req_q);
    lower_base = rd_start < pick_start_q;
    if (!pick_found_q) begin
      better = 1'b1;
    end else begin
      unique case (policy_q)
        POL_BEST:  better = (rd_len != pick_len_q) ? (rd_len < pick_len_q) : lower_base;
        POL_WORST: better = (rd_len != pick_len_q) ? (rd_len > pick_len_q) : lower_base;
        default:   better = lower_base;
      endcase
    end
  end

  // Commit of the chosen update and the result.
  always_comb begin
    we         = 1'b0;
    waddr      = pick_idx_q;
    wdata      = {pick_start_q + req_q[ADDR_WIDTH-1:0], pick_len_q - req_q};
    set_v      = 1'b0;
    clr_v      = 1'b0;
    res_base   = '0;
    res_status = STAT_OK;
    count_d    = count_q;
    if (func_q == FUNC_ALLOC) begin
      if (pick_found_q) begin
        we       = cmd_i.commit;
        res_base = FIELD_W'(pick_start_q);
        if (pick_len_q == req_q) begin
          clr_v   = 1'b1;
          count_d = count_q - CW'(1);
        end
      end else begin
        res_status = STAT_NOFIT;
      end
    end else if (nsize_q != '0) begin
      waddr = free_idx_q;
      wdata = {nbase_q, nsize_q};
      if (free_found_q) begin
        we      = cmd_i.commit;
        set_v   = 1'b1;
        count_d = count_q + CW'(1);
      end else begin
        res_status = STAT_FULL;
      end
    end
    count_ext = 32'(count_d);
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_func_i;
      req_q   <= in_data_i[FIELD_W-1:0];
      nbase_q <= in_data_i[FIELD_W+ADDR_WIDTH-1:FIELD_W];
      nsize_q <= in_data_i[3*FIELD_W-1:2*FIELD_W];
    end
    rd_idx_q <= idx_q;
    rd_v_q   <= valid_q[idx_q];
    if (rd_vld_q && fits && better) begin
      pick_idx_q   <= rd_idx_q;
      pick_start_q <= rd_start;
      pick_len_q   <= rd_len;
    end
    if (rd_vld_q && !rd_v_q && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_base_q   <= res_base;
      out_status_q <= res_status;
      out_holes_q  <= count_ext[HOLES_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      policy_q     <= POL_FIRST;
      idx_q        <= '0;
      rd_vld_q     <= 1'b0;
      pick_found_q <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        policy_q <= cfg_data_i;
      end
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        idx_q        <= '0;
        pick_found_q <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          idx_q <= idx_q + IW'(1);
        end
        if (rd_vld_q && fits) begin
          pick_found_q <= 1'b1;
        end
        if (rd_vld_q && !rd_v_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
        if (set_v) begin
          valid_q[waddr] <= 1'b1;
        end
        if (clr_v) begin
          valid_q[waddr] <= 1'b0;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = {3'b000, out_holes_q, out_base_q};
  assign out_status_o = out_status_q;

endmodule

// ----- hw/rtl/hole_table_fit_allocator.sv -----
// Top level of the hole table fit allocator.
// The scan reads one hole entry per cycle through the single read port of the hole memory,
// and no new item is taken until the result of the current one is committed.
// A finished result waits in the output register while the next item is taken.
// Reset is asynchronous, active low: the table empties and the policy is first fit.
module hole_table_fit_allocator #(
  parameter int unsigned MAX_HOLES  = 16,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] request_size, [63:32] new_hole_base, [95:64] new_hole_size
  input  logic [hta_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] func
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] granted_base, [36:32] holes_in_use, [39:37] zero
  output logic [hta_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [1:0]                         m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_data_i
);
  import hta_pkg::*;

  hta_cmd_t cmd;
  hta_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hta_dp #(
    .MAX_HOLES  (MAX_HOLES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata),
    .in_func_i    (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again while an item is in progress");

  // A result is committed only into a free output register.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result committed over a result not yet taken");

  // Only ok results carry a granted base.
  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STAT_NOFIT || m_axis_tuser == STAT_FULL))
      |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("nonzero base with a failing status");

  // Commands never overlap.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.scan, cmd.commit}))
    else $error("overlapping datapath commands");
`endif

endmodule
